### rtl/sctc_pkg.sv
// Package: shared types, constants and scan code tables for the scan code translator.
package sctc_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 256;
   localparam int LINK_DEPTH          = 2;
   localparam int RSP_DEPTH           = 4;

   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [7:0] CODE_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] CODE_RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] CODE_LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] CODE_RSHIFT_BREAK = 8'hB6;
   localparam logic [7:0] CODE_BACKSPACE    = 8'h0E;
   localparam logic [7:0] CODE_ENTER        = 8'h1C;
   localparam logic [7:0] CODE_UP           = 8'h48;
   localparam logic [7:0] CODE_DOWN         = 8'h50;
   localparam logic [7:0] CODE_LEFT         = 8'h4B;
   localparam logic [7:0] CODE_RIGHT        = 8'h4D;

   localparam logic [6:0] CHR_NONE      = 7'h00;
   localparam logic [6:0] CHR_BACKSPACE = 7'h08;
   localparam logic [6:0] CHR_ENTER     = 7'h0A;
   localparam logic [6:0] CHR_UP        = 7'h10;
   localparam logic [6:0] CHR_DOWN      = 7'h11;
   localparam logic [6:0] CHR_LEFT      = 7'h12;
   localparam logic [6:0] CHR_RIGHT     = 7'h13;

   // Classified operation handed from the front end to the back end.
   typedef struct packed {
      logic       is_read;
      logic [6:0] chr;
   } sctc_op_type;

   // One result item.
   typedef struct packed {
      logic       char_valid;
      logic [6:0] echo_char;
      logic [6:0] read_char;
      logic       available;
      logic       dropped;
   } sctc_rsp_type;

   function automatic logic [6:0] plain_char(input logic [6:0] idx);
      logic [6:0] c;
      case (idx)
         7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;  7'h05: c = 7'h34;
         7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;  7'h09: c = 7'h38;
         7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;  7'h0D: c = 7'h3D;
         7'h0E: c = 7'h08;  7'h0F: c = 7'h09;
         7'h10: c = 7'h71;  7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;
         7'h14: c = 7'h74;  7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;
         7'h18: c = 7'h6F;  7'h19: c = 7'h70;  7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;
         7'h1C: c = 7'h0A;  7'h1E: c = 7'h61;  7'h1F: c = 7'h73;
         7'h20: c = 7'h64;  7'h21: c = 7'h66;  7'h22: c = 7'h67;  7'h23: c = 7'h68;
         7'h24: c = 7'h6A;  7'h25: c = 7'h6B;  7'h26: c = 7'h6C;  7'h27: c = 7'h3B;
         7'h28: c = 7'h27;  7'h29: c = 7'h60;  7'h2B: c = 7'h5C;  7'h2C: c = 7'h7A;
         7'h2D: c = 7'h78;  7'h2E: c = 7'h63;  7'h2F: c = 7'h76;
         7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;  7'h33: c = 7'h2C;
         7'h34: c = 7'h2E;  7'h35: c = 7'h2F;  7'h37: c = 7'h2A;  7'h39: c = 7'h20;
         7'h47: c = 7'h37;
         7'h48: c = 7'h38;  7'h49: c = 7'h39;  7'h4A: c = 7'h2D;  7'h4B: c = 7'h34;
         7'h4C: c = 7'h35;  7'h4D: c = 7'h36;  7'h4E: c = 7'h2B;  7'h4F: c = 7'h31;
         7'h50: c = 7'h32;  7'h51: c = 7'h33;  7'h52: c = 7'h30;  7'h53: c = 7'h2E;
         default: c = CHR_NONE;
      endcase
      return c;
   endfunction

   // Shifted table: only the entries that differ from the plain table are listed.
   function automatic logic [6:0] shifted_char(input logic [6:0] idx);
      logic [6:0] c;
      case (idx)
         7'h02: c = 7'h21;  7'h03: c = 7'h40;  7'h04: c = 7'h23;  7'h05: c = 7'h24;
         7'h06: c = 7'h25;  7'h07: c = 7'h5E;  7'h08: c = 7'h26;  7'h09: c = 7'h2A;
         7'h0A: c = 7'h28;  7'h0B: c = 7'h29;  7'h0C: c = 7'h5F;  7'h0D: c = 7'h2B;
         7'h10: c = 7'h51;  7'h11: c = 7'h57;  7'h12: c = 7'h45;  7'h13: c = 7'h52;
         7'h14: c = 7'h54;  7'h15: c = 7'h59;  7'h16: c = 7'h55;  7'h17: c = 7'h49;
         7'h18: c = 7'h4F;  7'h19: c = 7'h50;  7'h1A: c = 7'h7B;  7'h1B: c = 7'h7D;
         7'h1E: c = 7'h41;  7'h1F: c = 7'h53;
         7'h20: c = 7'h44;  7'h21: c = 7'h46;  7'h22: c = 7'h47;  7'h23: c = 7'h48;
         7'h24: c = 7'h4A;  7'h25: c = 7'h4B;  7'h26: c = 7'h4C;  7'h27: c = 7'h3A;
         7'h28: c = 7'h22;  7'h29: c = 7'h7E;  7'h2B: c = 7'h7C;  7'h2C: c = 7'h5A;
         7'h2D: c = 7'h58;  7'h2E: c = 7'h43;  7'h2F: c = 7'h56;
         7'h30: c = 7'h42;  7'h31: c = 7'h4E;  7'h32: c = 7'h4D;  7'h33: c = 7'h3C;
         7'h34: c = 7'h3E;  7'h35: c = 7'h3F;
         default: c = plain_char(idx);
      endcase
      return c;
   endfunction

endpackage

### rtl/sctc_fifo.sv
// Small register-based FIFO used for the link queue and the result queue.
module sctc_fifo #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             almost_full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full        = (count_ff == CNT_W'(DEPTH));
   assign almost_full = (count_ff >= CNT_W'(DEPTH - 1));
   assign empty       = (count_ff == '0);
   assign do_push     = push && !full;
   assign do_pop      = pop && !empty;
   assign pop_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/sctc_front.sv
// Front end: accepts requests, tracks shift and translates scan codes to characters.
module sctc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_opcode,
   input  logic [7:0]           req_scan_byte,
   input  logic                 link_full,
   output logic                 op_push,
   output sctc_pkg::sctc_op_type op
);

   logic       shift_held_ff, shift_held_in;
   logic [6:0] chr;

   assign op_push = req_push && !link_full;

   always_comb begin
      shift_held_in = shift_held_ff;
      chr           = sctc_pkg::CHR_NONE;
      if (req_scan_byte == sctc_pkg::CODE_LSHIFT_MAKE ||
          req_scan_byte == sctc_pkg::CODE_RSHIFT_MAKE) begin
         shift_held_in = 1'b1;
      end else if (req_scan_byte == sctc_pkg::CODE_LSHIFT_BREAK ||
                   req_scan_byte == sctc_pkg::CODE_RSHIFT_BREAK) begin
         shift_held_in = 1'b0;
      end else if (req_scan_byte[7]) begin
         chr = sctc_pkg::CHR_NONE;
      end else if (req_scan_byte == sctc_pkg::CODE_BACKSPACE) begin
         chr = sctc_pkg::CHR_BACKSPACE;
      end else if (req_scan_byte == sctc_pkg::CODE_ENTER) begin
         chr = sctc_pkg::CHR_ENTER;
      end else if (req_scan_byte == sctc_pkg::CODE_UP) begin
         chr = sctc_pkg::CHR_UP;
      end else if (req_scan_byte == sctc_pkg::CODE_DOWN) begin
         chr = sctc_pkg::CHR_DOWN;
      end else if (req_scan_byte == sctc_pkg::CODE_LEFT) begin
         chr = sctc_pkg::CHR_LEFT;
      end else if (req_scan_byte == sctc_pkg::CODE_RIGHT) begin
         chr = sctc_pkg::CHR_RIGHT;
      end else if (shift_held_ff) begin
         chr = sctc_pkg::shifted_char(req_scan_byte[6:0]);
      end else begin
         chr = sctc_pkg::plain_char(req_scan_byte[6:0]);
      end
      op.is_read = (req_opcode == sctc_pkg::OP_READ);
      op.chr     = chr;
   end

   // Shift state moves only on an accepted scan byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_held_ff <= 1'b0;
      end else if (op_push && req_opcode == sctc_pkg::OP_SCAN) begin
         shift_held_ff <= shift_held_in;
      end
   end

endmodule

### rtl/sctc_back.sv
// Back end: character ring buffer, its pointers, and result assembly.
module sctc_back #(
   parameter int QUEUE_DEPTH = sctc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  op_valid,
   input  sctc_pkg::sctc_op_type  op,
   output logic                  op_pop,
   input  logic                  rsp_full,
   input  logic                  rsp_almost_full,
   output logic                  rsp_push,
   output sctc_pkg::sctc_rsp_type rsp_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   logic [6:0]       ring_mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_next, wr_next;
   logic             ring_we, ring_re;
   logic             issue;

   logic                   s1_valid_ff;
   sctc_pkg::sctc_rsp_type s1_rsp_ff, s1_rsp_in;
   logic                   s1_hit_ff, s1_hit_in;
   logic [6:0]             rd_data_ff;

   // Issue only when the result queue has room for this item and the one in flight.
   assign issue   = op_valid && !rsp_full && !(rsp_almost_full && s1_valid_ff);
   assign op_pop  = issue;
   assign rd_next = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
   assign wr_next = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      ring_we   = 1'b0;
      ring_re   = 1'b0;
      s1_hit_in = 1'b0;
      s1_rsp_in = '0;
      if (issue) begin
         if (op.is_read) begin
            if (rd_ptr_ff != wr_ptr_ff) begin
               ring_re   = 1'b1;
               s1_hit_in = 1'b1;
               rd_ptr_in = rd_next;
            end
         end else if (op.chr != sctc_pkg::CHR_NONE) begin
            s1_rsp_in.char_valid = 1'b1;
            s1_rsp_in.echo_char  = op.chr;
            if (wr_next != rd_ptr_ff) begin
               ring_we   = 1'b1;
               wr_ptr_in = wr_next;
            end else begin
               s1_rsp_in.dropped = 1'b1;
            end
         end
      end
      s1_rsp_in.available = (rd_ptr_in != wr_ptr_in);
   end

   always_comb begin
      rsp_push           = s1_valid_ff;
      rsp_data           = s1_rsp_ff;
      rsp_data.read_char = s1_hit_ff ? rd_data_ff : sctc_pkg::CHR_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      s1_rsp_ff <= s1_rsp_in;
      s1_hit_ff <= s1_hit_in;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wr_ptr_ff] <= op.chr;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_re) begin
         rd_data_ff <= ring_mem[rd_ptr_ff];
      end
   end

endmodule

### rtl/scancode_to_char_fifo.sv
// Top level: scan code set 1 translator with a character ring FIFO.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------------
//   request  | req_push / req_full | req_opcode, req_scan_byte
//   response | rsp_pop / rsp_empty | rsp_char_valid, rsp_echo_char, rsp_read_char,
//            |                     | rsp_available, rsp_dropped
//
// One item per cycle sustained while the consumer pops; each item makes a single ring access.
// A result reaches rsp_ via the link queue, the back-end register and the result queue.
// Reset clears the shift state, the ring pointers and both internal queues; the ring
// contents are not cleared and need no sweep.
// A stalled result side fills the four-entry result queue, then the two-entry link queue,
// and only then raises req_full.
module scancode_to_char_fifo #(
   parameter int QUEUE_DEPTH = sctc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_opcode,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_char_valid,
   output logic [6:0] rsp_echo_char,
   output logic [6:0] rsp_read_char,
   output logic       rsp_available,
   output logic       rsp_dropped
);

   localparam int OP_W  = $bits(sctc_pkg::sctc_op_type);
   localparam int RSP_W = $bits(sctc_pkg::sctc_rsp_type);

   // Front end to link queue.
   logic                   front_push;
   sctc_pkg::sctc_op_type  front_op;
   logic                   link_full;

   // Link queue to back end.
   logic                   link_empty;
   logic                   link_pop;
   logic [OP_W-1:0]        link_data;
   sctc_pkg::sctc_op_type  back_op;

   // Back end to result queue.
   logic                   back_push;
   sctc_pkg::sctc_rsp_type back_rsp;
   logic                   rsp_full;
   logic                   rsp_almost_full;
   logic [RSP_W-1:0]       rsp_data;
   sctc_pkg::sctc_rsp_type rsp_item;

   assign req_full = link_full;
   assign back_op  = sctc_pkg::sctc_op_type'(link_data);
   assign rsp_item = sctc_pkg::sctc_rsp_type'(rsp_data);

   // Drive the result ports straight from the head of the result queue.
   assign rsp_char_valid = rsp_item.char_valid;
   assign rsp_echo_char  = rsp_item.echo_char;
   assign rsp_read_char  = rsp_item.read_char;
   assign rsp_available  = rsp_item.available;
   assign rsp_dropped    = rsp_item.dropped;

   // Classify and translate each request, track shift.
   sctc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_opcode    (req_opcode),
      .req_scan_byte (req_scan_byte),
      .link_full     (link_full),
      .op_push       (front_push),
      .op            (front_op)
   );

   // Hold classified operations so front and back stall independently.
   sctc_fifo #(
      .DEPTH (sctc_pkg::LINK_DEPTH),
      .WIDTH (OP_W)
   ) u_link_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (front_push),
      .push_data   (front_op),
      .pop         (link_pop),
      .pop_data    (link_data),
      .full        (link_full),
      .almost_full (),
      .empty       (link_empty)
   );

   // Advance the character ring and assemble each result.
   sctc_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .op_valid        (!link_empty),
      .op              (back_op),
      .op_pop          (link_pop),
      .rsp_full        (rsp_full),
      .rsp_almost_full (rsp_almost_full),
      .rsp_push        (back_push),
      .rsp_data        (back_rsp)
   );

   // Queue finished results until the consumer pops them.
   sctc_fifo #(
      .DEPTH (sctc_pkg::RSP_DEPTH),
      .WIDTH (RSP_W)
   ) u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (back_push),
      .push_data   (back_rsp),
      .pop         (rsp_pop),
      .pop_data    (rsp_data),
      .full        (rsp_full),
      .almost_full (rsp_almost_full),
      .empty       (rsp_empty)
   );

endmodule

### rtl/sctc_checker.sv
// Port-level checker for the scan code translator, bound to the top level.
module sctc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_char_valid,
   input logic [6:0] rsp_echo_char,
   input logic [6:0] rsp_read_char,
   input logic       rsp_available,
   input logic       rsp_dropped
);

   // A character is flagged exactly when a nonzero echo accompanies it.
   a_echo_matches_valid: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_char_valid == (rsp_echo_char != 7'h00)))
      else $error("echo_char and char_valid disagree");

   // A drop means the queue was full: a character was seen and the queue stays nonempty.
   a_drop_consistent: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_dropped) |->
         (rsp_char_valid && rsp_available && rsp_read_char == 7'h00))
      else $error("dropped result is inconsistent");

   // A dequeued character never shares a result with an echo.
   a_read_excludes_echo: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_read_char != 7'h00) |-> !rsp_char_valid)
      else $error("read_char and char_valid both set");

   // A result waiting on the consumer holds.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_echo_char) && $stable(rsp_read_char) &&
          $stable(rsp_char_valid) && $stable(rsp_available) && $stable(rsp_dropped)))
      else $error("stalled result changed");

endmodule

bind scancode_to_char_fifo sctc_checker u_sctc_checker (.*);
